/* rtl/core/tsb_pkg.sv */
// Shared types and constants for the bilinear texture sampler.
// Used by every module of the block and by its port checker.
package tsb_pkg;

    // Default texture dimension (texels along one side of the store)
    localparam int TEX_DIM_DEF = 256;

    // Size register width and reset value
    localparam int          REG_W     = 9;
    localparam logic [8:0]  REG_RESET = 9'd256;

    // Configuration port
    localparam int          PADDR_W     = 3;
    localparam logic [2:0]  ADDR_WIDTH  = 3'd0;
    localparam logic [2:0]  ADDR_HEIGHT = 3'd4;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_BLEND    = 2'd0,
        REQ_NEAREST  = 2'd1,
        REQ_BILINEAR = 2'd2,
        REQ_FILL     = 2'd3
    } req_t;

    // Texel store port control
    typedef struct packed {
        logic en;
        logic we;
    } mem_ctl_t;

endpackage

/* rtl/core/tsb_texmem.sv */
// Single-port synchronous texel store with a registered read.
// Depends on tsb_pkg for the port control struct.
module tsb_texmem #(
    parameter int TEX_DIM = tsb_pkg::TEX_DIM_DEF
) (
    input  logic                                 clk,
    input  tsb_pkg::mem_ctl_t                    ctl,
    input  logic [$clog2(TEX_DIM*TEX_DIM)-1:0]   addr,
    input  logic [31:0]                          wdata,
    output logic [31:0]                          rdata
);

    localparam int DEPTH = TEX_DIM * TEX_DIM;

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // One access per cycle: write or registered read
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tsb_coord.sv */
// Sample position unit: scales Q2.14 coordinates by (size - 1/2) and splits
// the result into integer texel and 8-bit fraction. Depends on tsb_pkg.
module tsb_coord #(
    parameter int TEX_DIM = tsb_pkg::TEX_DIM_DEF,
    localparam int DW = $clog2(TEX_DIM + 1),
    localparam int XW = (DW + 3 > 10) ? DW + 3 : 10
) (
    input  logic                  clk,
    input  logic                  en,
    input  tsb_pkg::req_t         req,
    input  logic [7:0]            tex_x,
    input  logic [7:0]            tex_y,
    input  logic signed [15:0]    coord_s,
    input  logic signed [15:0]    coord_t,
    input  logic [DW-1:0]         w_eff,
    input  logic [DW-1:0]         h_eff,
    output logic signed [XW-1:0]  x0,
    output logic signed [XW-1:0]  y0,
    output logic [7:0]            fs,
    output logic [7:0]            ft
);

    localparam int PW = 16 + DW + 2;

    logic signed [DW+1:0] kw, kh;
    logic signed [PW-1:0] ps, pt;
    logic signed [XW-1:0] x0_reg, y0_reg, x0_next, y0_next;
    logic [7:0]           fs_reg, ft_reg;

    // Scale factor 2*D - 1; the product shifted by 7 is P, by 15 the texel
    assign kw = $signed({1'b0, w_eff, 1'b0}) - $signed((DW + 2)'(1));
    assign kh = $signed({1'b0, h_eff, 1'b0}) - $signed((DW + 2)'(1));
    assign ps = coord_s * kw;
    assign pt = coord_t * kh;

    // Blend writes address the texel directly
    always_comb
    begin
        if (req == tsb_pkg::REQ_BLEND)
        begin
            x0_next = $signed({{(XW - 8){1'b0}}, tex_x});
            y0_next = $signed({{(XW - 8){1'b0}}, tex_y});
        end
        else
        begin
            x0_next = XW'($signed(ps[PW-1:15]));
            y0_next = XW'($signed(pt[PW-1:15]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            fs_reg <= ps[14:7];
            ft_reg <= pt[14:7];
        end
    end

    assign x0 = x0_reg;
    assign y0 = y0_reg;
    assign fs = fs_reg;
    assign ft = ft_reg;

endmodule

/* rtl/core/tsb_ctrl.sv */
// Request sequencer: tap reads, blend read-modify-write, bilinear weighting,
// fill and reset sweeps, output register. Depends on tsb_pkg.
module tsb_ctrl #(
    parameter int TEX_DIM = tsb_pkg::TEX_DIM_DEF,
    localparam int DW = $clog2(TEX_DIM + 1),
    localparam int XW = (DW + 3 > 10) ? DW + 3 : 10,
    localparam int AW = $clog2(TEX_DIM * TEX_DIM)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request side
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tsb_pkg::req_t         in_req,
    input  logic [7:0]            in_tex_x,
    input  logic [7:0]            in_tex_y,
    input  logic signed [15:0]    in_coord_s,
    input  logic signed [15:0]    in_coord_t,
    input  logic [31:0]           in_color,
    // result side
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           out_color,
    // sizes
    input  logic [DW-1:0]         w_eff,
    input  logic [DW-1:0]         h_eff,
    // position unit
    output logic                  pos_en,
    output tsb_pkg::req_t         item_req,
    output logic [7:0]            item_tex_x,
    output logic [7:0]            item_tex_y,
    output logic signed [15:0]    item_coord_s,
    output logic signed [15:0]    item_coord_t,
    input  logic signed [XW-1:0]  x0,
    input  logic signed [XW-1:0]  y0,
    input  logic [7:0]            fs,
    input  logic [7:0]            ft,
    // texel store
    output tsb_pkg::mem_ctl_t     mem_ctl,
    output logic [AW-1:0]         mem_addr,
    output logic [31:0]           mem_wdata,
    input  logic [31:0]           mem_rdata
);

    localparam int DEPTH = TEX_DIM * TEX_DIM;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_POS, S_READ, S_DRAIN, S_PICK,
        S_BLEND, S_FILT, S_SUM, S_DONE, S_FILL
    } state_t;

    // Mix one channel by alpha with rounding; divide by 255 via shift-add
    function automatic logic [7:0] blend_chan(input logic [7:0] o, input logic [7:0] n,
                                              input logic [7:0] a);
        logic [16:0] mix;
        logic [16:0] q;
        mix = 17'(o * (8'd255 - a)) + 17'(n * a) + 17'd127;
        q   = (mix + (mix >> 8) + 17'd1) >> 8;
        return q[7:0];
    endfunction

    state_t               state_reg, state_next;
    logic [1:0]           tap_cnt_reg, tap_cnt_next;
    logic [AW-1:0]        sweep_reg, sweep_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [1:0]           rd_tap_reg, rd_tap_next;
    logic                 rd_inr_reg, rd_inr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_color_reg, out_color_next;
    logic [31:0]          result_reg, result_next;
    logic [31:0]          taps_reg [4];
    logic [31:0]          taps_next [4];
    logic [16:0]          top_reg [4];
    logic [16:0]          bot_reg [4];
    logic [16:0]          top_next [4];
    logic [16:0]          bot_next [4];
    tsb_pkg::req_t        req_reg;
    logic [7:0]           tex_x_reg, tex_y_reg;
    logic signed [15:0]   coord_s_reg, coord_t_reg;
    logic [31:0]          color_reg;

    logic                 accept;
    logic signed [XW-1:0] tx, ty;
    logic                 tap_inr;
    logic [2*DW-1:0]      lin;
    logic [1:0]           last_tap;
    logic [8:0]           fs_w, ft_w;
    logic [31:0]          blend_val, filt_val;

    assign accept = in_valid && (state_reg == S_IDLE);
    assign in_ready = (state_reg == S_IDLE);

    // Tap address: tap bit 0 steps x, bit 1 steps y
    assign tx = x0 + $signed({{(XW - 1){1'b0}}, tap_cnt_reg[0]});
    assign ty = y0 + $signed({{(XW - 1){1'b0}}, tap_cnt_reg[1]});
    assign tap_inr = !tx[XW-1] && !ty[XW-1]
                     && (tx < $signed({{(XW - DW){1'b0}}, w_eff}))
                     && (ty < $signed({{(XW - DW){1'b0}}, h_eff}));
    assign lin = (2 * DW)'(tx[DW-1:0]) + ty[DW-1:0] * w_eff;
    assign last_tap = (req_reg == tsb_pkg::REQ_BILINEAR) ? 2'd3 : 2'd0;

    // Blend of the new color over the old texel
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            blend_val[8*k +: 8] = blend_chan(taps_reg[0][8*k +: 8], color_reg[8*k +: 8],
                                             color_reg[31:24]);
    end

    // Bilinear weights: horizontal pass, then vertical pass with rounding
    assign fs_w = 9'd256 - {1'b0, fs};
    assign ft_w = 9'd256 - {1'b0, ft};

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            top_next[k] = 17'(taps_reg[0][8*k +: 8] * fs_w) + 17'(taps_reg[1][8*k +: 8] * fs);
            bot_next[k] = 17'(taps_reg[2][8*k +: 8] * fs_w) + 17'(taps_reg[3][8*k +: 8] * fs);
        end
    end

    always_comb
    begin
        logic [26:0] sum;
        logic [10:0] v;
        for (int k = 0; k < 4; k++)
        begin
            sum = 27'(top_reg[k] * ft_w) + 27'(bot_reg[k] * ft) + 27'd32768;
            v   = sum[26:16];
            filt_val[8*k +: 8] = (v > 11'd255) ? 8'd255 : v[7:0];
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        tap_cnt_next   = tap_cnt_reg;
        sweep_next     = sweep_reg;
        rd_pend_next   = 1'b0;
        rd_tap_next    = rd_tap_reg;
        rd_inr_next    = rd_inr_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_color_next = out_color_reg;
        for (int k = 0; k < 4; k++)
            taps_next[k] = taps_reg[k];
        mem_ctl   = '0;
        mem_addr  = lin[AW-1:0];
        mem_wdata = blend_val;
        pos_en    = 1'b0;

        // capture the texel read in the previous cycle
        if (rd_pend_reg)
            taps_next[rd_tap_reg] = rd_inr_reg ? mem_rdata : 32'd0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_ctl   = '{en: 1'b1, we: 1'b1};
                mem_addr  = sweep_reg;
                mem_wdata = 32'd0;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_IDX)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                sweep_next   = '0;
                tap_cnt_next = 2'd0;
                if (accept)
                    state_next = (in_req == tsb_pkg::REQ_FILL) ? S_FILL : S_POS;
            end
            S_POS:
            begin
                pos_en     = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                mem_ctl      = '{en: tap_inr, we: 1'b0};
                rd_pend_next = 1'b1;
                rd_tap_next  = tap_cnt_reg;
                rd_inr_next  = tap_inr;
                if (tap_cnt_reg == last_tap)
                    state_next = S_DRAIN;
                else
                    tap_cnt_next = tap_cnt_reg + 2'd1;
            end
            S_DRAIN:
            begin
                priority case (req_reg)
                    tsb_pkg::REQ_BLEND:    state_next = S_BLEND;
                    tsb_pkg::REQ_BILINEAR: state_next = S_FILT;
                    default:               state_next = S_PICK;
                endcase
            end
            S_PICK:
            begin
                result_next = taps_reg[0];
                state_next  = S_DONE;
            end
            S_BLEND:
            begin
                mem_ctl     = '{en: tap_inr, we: 1'b1};
                result_next = 32'd0;
                state_next  = S_DONE;
            end
            S_FILT:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                result_next = filt_val;
                state_next  = S_DONE;
            end
            S_FILL:
            begin
                mem_ctl     = '{en: 1'b1, we: 1'b1};
                mem_addr    = sweep_reg;
                mem_wdata   = color_reg;
                sweep_next  = sweep_reg + AW'(1);
                result_next = 32'd0;
                if (sweep_reg == LAST_IDX)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_color_next = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            tap_cnt_reg   <= 2'd0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            tap_cnt_reg   <= tap_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        rd_tap_reg    <= rd_tap_next;
        rd_inr_reg    <= rd_inr_next;
        result_reg    <= result_next;
        out_color_reg <= out_color_next;
        for (int k = 0; k < 4; k++)
        begin
            taps_reg[k] <= taps_next[k];
            top_reg[k]  <= top_next[k];
            bot_reg[k]  <= bot_next[k];
        end
        if (accept)
        begin
            req_reg     <= in_req;
            tex_x_reg   <= in_tex_x;
            tex_y_reg   <= in_tex_y;
            coord_s_reg <= in_coord_s;
            coord_t_reg <= in_coord_t;
            color_reg   <= in_color;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_color    = out_color_reg;
    assign item_req     = req_reg;
    assign item_tex_x   = tex_x_reg;
    assign item_tex_y   = tex_y_reg;
    assign item_coord_s = coord_s_reg;
    assign item_coord_t = coord_t_reg;

endmodule

/* rtl/core/texture_sampler_bilinear_blend.sv */
// Top level of the bilinear texture sampler: APB size registers, position
// unit, sequencer and texel store. Depends on tsb_pkg and all tsb_* modules.
//
// Texture unit over a TEX_DIM x TEX_DIM store of RGBA8 texels in one
// single-port synchronous memory; every request returns exactly one result
// transfer. Requests are handled one at a time: a new request is taken only
// once the result of the last one has gone to the output register. A nearest
// sample or a blend write (read, then write back) reads one texel, a bilinear
// sample reads four texels, and a fill sweeps the store one texel a cycle.
// After reset the store is cleared by the same sweep: no request is taken
// until the sweep ends, while register writes are taken at any time.
// Registers: tex_width at 0x0, tex_height at 0x4 (9 bits, reset 256).
module texture_sampler_bilinear_blend #(
    parameter int TEX_DIM = tsb_pkg::TEX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tex_x[7:0], tex_y[15:8], coord_s[31:16], coord_t[47:32], texel_color[79:48]
    input  logic [79:0]                   s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]                    s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // sample_color[31:0]
    output logic [31:0]                   m_axis_tdata,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int DW = $clog2(TEX_DIM + 1);
    localparam int XW = (DW + 3 > 10) ? DW + 3 : 10;
    localparam int AW = $clog2(TEX_DIM * TEX_DIM);

    logic [tsb_pkg::REG_W-1:0] width_reg, height_reg;
    logic [DW-1:0]             w_eff, h_eff;
    logic                      cfg_wr;

    logic                      pos_en;
    tsb_pkg::req_t             item_req;
    logic [7:0]                item_tex_x, item_tex_y;
    logic signed [15:0]        item_coord_s, item_coord_t;
    logic signed [XW-1:0]      x0, y0;
    logic [7:0]                fs, ft;
    tsb_pkg::mem_ctl_t         mem_ctl;
    logic [AW-1:0]             mem_addr;
    logic [31:0]               mem_wdata, mem_rdata;

    // Register writes complete in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tsb_pkg::REG_RESET;
            height_reg <= tsb_pkg::REG_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr == tsb_pkg::ADDR_WIDTH)
                width_reg <= pwdata[tsb_pkg::REG_W-1:0];
            else if (paddr == tsb_pkg::ADDR_HEIGHT)
                height_reg <= pwdata[tsb_pkg::REG_W-1:0];
        end
    end

    // Register readback
    always_comb
    begin
        prdata = 32'd0;
        if (paddr == tsb_pkg::ADDR_WIDTH)
            prdata = 32'(width_reg);
        else if (paddr == tsb_pkg::ADDR_HEIGHT)
            prdata = 32'(height_reg);
    end

    // Sizes saturate at the store dimension
    assign w_eff = (32'(width_reg) > 32'(TEX_DIM)) ? DW'(TEX_DIM) : DW'(width_reg);
    assign h_eff = (32'(height_reg) > 32'(TEX_DIM)) ? DW'(TEX_DIM) : DW'(height_reg);

    tsb_coord #(.TEX_DIM(TEX_DIM)) u_coord (
        .clk     (clk),
        .en      (pos_en),
        .req     (item_req),
        .tex_x   (item_tex_x),
        .tex_y   (item_tex_y),
        .coord_s (item_coord_s),
        .coord_t (item_coord_t),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .x0      (x0),
        .y0      (y0),
        .fs      (fs),
        .ft      (ft)
    );

    tsb_ctrl #(.TEX_DIM(TEX_DIM)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_req       (tsb_pkg::req_t'(s_axis_tuser)),
        .in_tex_x     (s_axis_tdata[7:0]),
        .in_tex_y     (s_axis_tdata[15:8]),
        .in_coord_s   (s_axis_tdata[31:16]),
        .in_coord_t   (s_axis_tdata[47:32]),
        .in_color     (s_axis_tdata[79:48]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_color    (m_axis_tdata),
        .w_eff        (w_eff),
        .h_eff        (h_eff),
        .pos_en       (pos_en),
        .item_req     (item_req),
        .item_tex_x   (item_tex_x),
        .item_tex_y   (item_tex_y),
        .item_coord_s (item_coord_s),
        .item_coord_t (item_coord_t),
        .x0           (x0),
        .y0           (y0),
        .fs           (fs),
        .ft           (ft),
        .mem_ctl      (mem_ctl),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata)
    );

    tsb_texmem #(.TEX_DIM(TEX_DIM)) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

/* rtl/core/tsb_checker.sv */
// Port-level checks for the bilinear texture sampler, bound to the top level.
// Depends on tsb_pkg for the configuration address width.
module tsb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [31:0]                  m_axis_tdata,
    input logic                         pready,
    input logic [tsb_pkg::PADDR_W-1:0]  paddr
);

    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // One request in work at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    // Store clearing after reset blocks requests
    a_clear_busy: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !s_axis_tready)
        else $error("request taken during clearing sweep");

    // Config port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready || (paddr != paddr))
        else $error("pready low");

endmodule

bind texture_sampler_bilinear_blend tsb_checker u_tsb_checker (.*);

/* tb/tb_texture_sampler_bilinear_blend.sv */
// Testbench for texture_sampler_bilinear_blend: a directed table, then random
// blend, sample and fill requests checked against a texel-store predictor.
// Depends on tsb_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_texture_sampler_bilinear_blend;

    localparam int DIM = tsb_pkg::TEX_DIM_DEF;
    localparam int DIRECTED_N = 20;
    localparam int RANDOM_N = 440;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [tsb_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typedef struct {
        tsb_pkg::req_t kind;
        logic [7:0]  tx;
        logic [7:0]  ty;
        logic [15:0] cs;
        logic [15:0] ct;
        logic [31:0] color;
        logic        has_exp;
        logic [31:0] exp_color;
    } tex_req_t;

    // predictor state
    logic [31:0] texels [DIM*DIM];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [31:0] color_q [$];
    int          err_count;
    int          hold_cycles;

    texture_sampler_bilinear_blend u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit: reset sweep, 3 fills and about 460 slow requests with stalls
    initial
    begin
        #60ms;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %08h want %08h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic int size_of(input logic [8:0] r);
        return (r > DIM) ? DIM : int'(r);
    endfunction

    function automatic longint floor_by(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q -= 1;
        return q;
    endfunction

    function automatic logic [31:0] texel_at(input longint x, input longint y,
                                             input int w, input int h);
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 32'd0;
        return texels[x + y * w];
    endfunction

    // update the store model and return the expected sample color
    function automatic logic [31:0] predict_color(input tex_req_t r);
        int w, h;
        longint ps, pt, x, y;
        int fs, ft, a, o, n, top, bot;
        longint sum;
        logic [31:0] res, old, c00, c10, c01, c11;
        res = 32'd0;
        w = size_of(width_reg);
        h = size_of(height_reg);
        case (r.kind)
            tsb_pkg::REQ_BLEND:
            begin
                if (r.tx < w && r.ty < h)
                begin
                    old = texels[r.tx + r.ty * w];
                    a = r.color[31:24];
                    for (int k = 0; k < 4; k++)
                    begin
                        o = old[8*k +: 8];
                        n = r.color[8*k +: 8];
                        res[8*k +: 8] = 8'((o * (255 - a) + n * a + 127) / 255);
                    end
                    texels[r.tx + r.ty * w] = res;
                    res = 32'd0;
                end
            end
            tsb_pkg::REQ_FILL:
            begin
                foreach (texels[i])
                    texels[i] = r.color;
            end
            default:
            begin
                ps = floor_by(longint'($signed(r.cs)) * (2 * w - 1), 128);
                pt = floor_by(longint'($signed(r.ct)) * (2 * h - 1), 128);
                x = floor_by(ps, 256);
                y = floor_by(pt, 256);
                if (r.kind == tsb_pkg::REQ_NEAREST)
                    res = texel_at(x, y, w, h);
                else
                begin
                    fs = int'(ps - x * 256);
                    ft = int'(pt - y * 256);
                    c00 = texel_at(x, y, w, h);
                    c10 = texel_at(x + 1, y, w, h);
                    c01 = texel_at(x, y + 1, w, h);
                    c11 = texel_at(x + 1, y + 1, w, h);
                    for (int k = 0; k < 4; k++)
                    begin
                        top = c00[8*k +: 8] * (256 - fs) + c10[8*k +: 8] * fs;
                        bot = c01[8*k +: 8] * (256 - fs) + c11[8*k +: 8] * fs;
                        sum = (longint'(top) * (256 - ft) + longint'(bot) * ft + 32768) >>> 16;
                        if (sum > 255)
                            sum = 255;
                        res[8*k +: 8] = 8'(sum);
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic reg_write(input logic [tsb_pkg::PADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == tsb_pkg::ADDR_WIDTH)
            width_reg = data[8:0];
        else
            height_reg = data[8:0];
        @(posedge clk);
    endtask

    // wait for the result queue to drain, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (color_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_size(input int w, input int h);
        drain_results();
        reg_write(tsb_pkg::ADDR_WIDTH, 32'(w));
        reg_write(tsb_pkg::ADDR_HEIGHT, 32'(h));
    endtask

    // one request transfer, with a random gap first
    task automatic send_req(input tex_req_t r, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {r.color, r.ct, r.cs, r.ty, r.tx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        color_q.push_back(r.has_exp ? r.exp_color : predict_color(r));
        if (r.has_exp)
            void'(predict_color(r));
    endtask

    function automatic tex_req_t mk(input tsb_pkg::req_t k, input logic [7:0] x,
                                    input logic [7:0] y,
                                    input logic [15:0] s, input logic [15:0] t,
                                    input logic [31:0] c, input logic he, input logic [31:0] e);
        tex_req_t r;
        r.kind = k; r.tx = x; r.ty = y; r.cs = s; r.ct = t;
        r.color = c; r.has_exp = he; r.exp_color = e;
        return r;
    endfunction

    function automatic tex_req_t rand_req(input int w, input int h);
        tex_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.kind = (pick < 40) ? tsb_pkg::REQ_BLEND :
                 (pick < 65) ? tsb_pkg::REQ_NEAREST : tsb_pkg::REQ_BILINEAR;
        r.tx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, w));
        r.ty = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, h));
        r.color = $urandom;
        // mostly coordinates in [0,1], sometimes anywhere
        r.cs = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384));
        r.ct = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384));
        r.has_exp = 1'b0;
        r.exp_color = 32'd0;
        return r;
    endfunction

    // receiver: random stalls, one long hold-off
    initial
    begin
        int gap;
        logic [31:0] want;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            if (color_q.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata, 32'd0);
            end
            else
            begin
                want = color_q.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch("sample_color", m_axis_tdata, want);
            end
        end
    end

    // sender and phase control
    initial
    begin
        tex_req_t table_rows [DIRECTED_N];
        int w, h, phase;
        err_count = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = tsb_pkg::REQ_BLEND;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        width_reg = tsb_pkg::REG_RESET;
        height_reg = tsb_pkg::REG_RESET;
        foreach (texels[i])
            texels[i] = 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: cleared store, extremes, out of range, fills
        table_rows[0]  = mk(tsb_pkg::REQ_NEAREST,  0, 0, 16'h0000, 16'h0000, 0, 1, 32'd0);
        table_rows[1]  = mk(tsb_pkg::REQ_BILINEAR, 0, 0, 16'h7fff, 16'h8000, 0, 1, 32'd0);
        table_rows[2]  = mk(tsb_pkg::REQ_BLEND,    0, 0, 0, 0, 32'hff11_2233, 1, 32'd0);
        table_rows[3]  = mk(tsb_pkg::REQ_NEAREST,  0, 0, 16'h0000, 16'h0000, 0, 1,
                            32'hff11_2233);
        table_rows[4]  = mk(tsb_pkg::REQ_BLEND,    255, 255, 16'hffff, 16'hffff,
                            32'h8080_ffff, 1, 0);
        table_rows[5]  = mk(tsb_pkg::REQ_BLEND,    0, 0, 0, 0, 32'h00ff_ffff, 1, 32'd0);
        table_rows[6]  = mk(tsb_pkg::REQ_NEAREST,  0, 0, 16'h3fff, 16'h3fff, 0, 0, 0);
        table_rows[7]  = mk(tsb_pkg::REQ_BILINEAR, 0, 0, 16'h0000, 16'h0000, 0, 0, 0);
        table_rows[8]  = mk(tsb_pkg::REQ_BILINEAR, 0, 0, 16'h3fff, 16'h3fff, 0, 0, 0);
        table_rows[9]  = mk(tsb_pkg::REQ_NEAREST,  0, 0, 16'h4000, 16'h0000, 0, 1, 32'd0);
        table_rows[10] = mk(tsb_pkg::REQ_NEAREST,  0, 0, 16'hffff, 16'h0000, 0, 1, 32'd0);
        table_rows[11] = mk(tsb_pkg::REQ_FILL,     0, 0, 0, 0, 32'hffff_ffff, 1, 32'd0);
        table_rows[12] = mk(tsb_pkg::REQ_BILINEAR, 0, 0, 16'h2000, 16'h2000, 0, 1,
                            32'hffff_ffff);
        table_rows[13] = mk(tsb_pkg::REQ_NEAREST,  0, 0, 16'h7fff, 16'h7fff, 0, 1, 32'd0);
        table_rows[14] = mk(tsb_pkg::REQ_BILINEAR, 0, 0, 16'h3fff, 16'h1000, 0, 0, 0);
        table_rows[15] = mk(tsb_pkg::REQ_BLEND,    17, 3, 0, 0, 32'h4012_3456, 0, 0);
        table_rows[16] = mk(tsb_pkg::REQ_FILL,     0, 0, 0, 0, 32'h0000_0000, 1, 32'd0);
        table_rows[17] = mk(tsb_pkg::REQ_BLEND,    1, 0, 0, 0, 32'hffa5_5a0f, 1, 32'd0);
        table_rows[18] = mk(tsb_pkg::REQ_BILINEAR, 0, 0, 16'h0040, 16'h0000, 0, 0, 0);
        table_rows[19] = mk(tsb_pkg::REQ_BILINEAR, 0, 0, 16'h8000, 16'hc000, 0, 1, 32'd0);
        foreach (table_rows[i])
            send_req(table_rows[i], $urandom_range(0, 3));

        // random phases over several sizes, extremes among them
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin w = 1;   h = 1;   end
                1: begin w = 2;   h = 3;   end
                2: begin w = 0;   h = 5;   end
                3: begin w = 511; h = 300; end
                4: begin w = 4;   h = 4;   end
                5: begin w = 256; h = 1;   end
                6: begin w = 7;   h = 0;   end
                default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
            endcase
            set_size(w, h);
            if (phase == 4)
                send_req(mk(tsb_pkg::REQ_FILL, 0, 0, 0, 0, $urandom, 0, 0), 0);
            if (phase == 1)
                hold_cycles = 300;
            for (int i = 0; i < RANDOM_N / 8; i++)
            begin
                // one pause until every result is back
                if (phase == 5 && i == 20)
                    drain_results();
                send_req(rand_req(size_of(9'(w)), size_of(9'(h))),
                         (phase == 1 && i < 20) ? 0 : $urandom_range(0, 3));
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
